>>> hdl/shortest_job_first_queue_unit_assert.svh
// Assertion macros for the shortest-job-first queue checker
`ifndef SHORTEST_JOB_FIRST_QUEUE_UNIT_ASSERT_SVH
`define SHORTEST_JOB_FIRST_QUEUE_UNIT_ASSERT_SVH

// check a consequence in the same cycle
`define SJFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sjfq check failed");

// check a consequence in the following cycle
`define SJFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sjfq check failed");

`endif

>>> hdl/sjfq_pkg.sv
// Shared constants, codes and types of the shortest-job-first queue
`timescale 1ns / 1ps
package sjfq_pkg;

  localparam int DEPTH      = 32;
  localparam int BURST_BITS = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int BURST_W  = 16;
  localparam int ID_W     = 5;
  localparam int TIME_W   = 21;
  localparam int SUM_W    = 26;
  localparam int STATUS_W = 2;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic refuse;
    logic empty_res;
    logic begin_run;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } stat_t;

endpackage

>>> hdl/sjfq_ctrl.sv
// Controller state machine of the shortest-job-first queue
`timescale 1ns / 1ps
module sjfq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            command,
  input  sjfq_pkg::stat_t stat,
  output logic            busy,
  output sjfq_pkg::ctrl_t ctrl
);
  import sjfq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_ADD) begin
            if (stat.full) begin
              ctrl.refuse = 1'b1;
            end else begin
              ctrl.insert = 1'b1;
            end
          end else if (stat.empty) begin
            ctrl.empty_res = 1'b1;
          end else begin
            ctrl.begin_run = 1'b1;
            state_next     = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        busy      = 1'b1;
        ctrl.step = 1'b1;
        if (stat.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/sjfq_datapath.sv
// Sorted queue cells, run accumulators and result registers
`timescale 1ns / 1ps
module sjfq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sjfq_pkg::ctrl_t                 ctrl,
  input  logic [sjfq_pkg::BURST_W-1:0]    burst,
  output sjfq_pkg::stat_t                 stat,
  output logic                            strobe,
  output logic [sjfq_pkg::STATUS_W-1:0]   status,
  output logic [sjfq_pkg::ID_W-1:0]       task_id,
  output logic [sjfq_pkg::BURST_W-1:0]    burst_out,
  output logic [sjfq_pkg::TIME_W-1:0]     start_time,
  output logic [sjfq_pkg::TIME_W-1:0]     finish_time,
  output logic [sjfq_pkg::SUM_W-1:0]      total_waiting,
  output logic [sjfq_pkg::SUM_W-1:0]      total_turnaround,
  output logic                            is_last
);
  import sjfq_pkg::*;

  logic [BURST_BITS-1:0] q_burst [DEPTH];
  logic [ID_W-1:0]       q_id    [DEPTH];
  logic [CNT_W-1:0]      task_count;
  logic [SUM_W-1:0]      now, tw, tt;
  logic [BURST_BITS-1:0] b_in;
  logic [DEPTH-1:0]      gt, at_end;
  logic [SUM_W-1:0]      head_burst, fin;

  assign b_in       = BURST_BITS'(burst);
  assign head_burst = SUM_W'(q_burst[0]);
  assign fin        = now + head_burst;

  assign stat.full  = (task_count == CNT_W'(DEPTH));
  assign stat.empty = (task_count == '0);
  assign stat.last  = (task_count == CNT_W'(1));

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                  prev_gt;
    logic [BURST_BITS-1:0] prev_b, next_b;
    logic [ID_W-1:0]       prev_i, next_i;

    if (k == 0) begin : g_head
      assign prev_gt = 1'b0;
      assign prev_b  = '0;
      assign prev_i  = '0;
    end else begin : g_body
      assign prev_gt = gt[k-1];
      assign prev_b  = q_burst[k-1];
      assign prev_i  = q_id[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign next_b = q_burst[k];
      assign next_i = q_id[k];
    end else begin : g_inner
      assign next_b = q_burst[k+1];
      assign next_i = q_id[k+1];
    end

    assign gt[k]     = (CNT_W'(k) < task_count) && (q_burst[k] > b_in);
    assign at_end[k] = (CNT_W'(k) == task_count);

    always_ff @(posedge clk) begin
      if (ctrl.insert) begin
        if (prev_gt) begin
          q_burst[k] <= prev_b;
          q_id[k]    <= prev_i;
        end else if (gt[k] || at_end[k]) begin
          q_burst[k] <= b_in;
          q_id[k]    <= ID_W'(task_count);
        end
      end else if (ctrl.step) begin
        q_burst[k] <= next_b;
        q_id[k]    <= next_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
    end else if (ctrl.insert) begin
      task_count <= task_count + CNT_W'(1);
    end else if (ctrl.step) begin
      task_count <= task_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.begin_run) begin
      now <= '0;
      tw  <= '0;
      tt  <= '0;
    end else if (ctrl.step) begin
      now <= fin;
      tw  <= tw + now;
      tt  <= tt + fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.refuse | ctrl.empty_res | ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.refuse || ctrl.empty_res) begin
      status           <= ctrl.refuse ? ST_FULL : ST_EMPTY;
      task_id          <= '0;
      burst_out        <= '0;
      start_time       <= '0;
      finish_time      <= '0;
      total_waiting    <= '0;
      total_turnaround <= '0;
      is_last          <= ctrl.empty_res;
    end else if (ctrl.step) begin
      status           <= ST_DISPATCHED;
      task_id          <= q_id[0];
      burst_out        <= BURST_W'(q_burst[0]);
      start_time       <= TIME_W'(now);
      finish_time      <= TIME_W'(fin);
      total_waiting    <= tw + now;
      total_turnaround <= tt + fin;
      is_last          <= stat.last;
    end
  end

endmodule

>>> hdl/shortest_job_first_queue_unit.sv
// Top level of the shortest-job-first queue
//
// Items enter on start while busy is low. An add is stored by a row of
// compare-and-shift cells that keeps the queue sorted by burst, so adds may follow
// back to back. A refused add (queue full) or a dispatch of an empty queue gives its
// single result in the cycle after the item. A dispatch of n tasks raises busy
// while the queue drains from its head one entry per cycle; the n results are
// registered from those steps and appear one per cycle, the last with is_last set.
// Each result shows for exactly one cycle under strobe and cannot be held off, so
// the receiver must take it then.
`timescale 1ns / 1ps
module shortest_job_first_queue_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [sjfq_pkg::BURST_W-1:0]    burst,
  output logic                            strobe,
  output logic [sjfq_pkg::STATUS_W-1:0]   status,
  output logic [sjfq_pkg::ID_W-1:0]       task_id,
  output logic [sjfq_pkg::BURST_W-1:0]    burst_out,
  output logic [sjfq_pkg::TIME_W-1:0]     start_time,
  output logic [sjfq_pkg::TIME_W-1:0]     finish_time,
  output logic [sjfq_pkg::SUM_W-1:0]      total_waiting,
  output logic [sjfq_pkg::SUM_W-1:0]      total_turnaround,
  output logic                            is_last
);
  import sjfq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  sjfq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  sjfq_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .burst            (burst),
    .stat             (stat),
    .strobe           (strobe),
    .status           (status),
    .task_id          (task_id),
    .burst_out        (burst_out),
    .start_time       (start_time),
    .finish_time      (finish_time),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .is_last          (is_last)
  );

endmodule

>>> hdl/sjfq_checker.sv
// Port-level checks of the shortest-job-first queue and their binding
`timescale 1ns / 1ps
`include "shortest_job_first_queue_unit_assert.svh"
module sjfq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            strobe,
  input logic [sjfq_pkg::STATUS_W-1:0]   status,
  input logic [sjfq_pkg::ID_W-1:0]       task_id,
  input logic [sjfq_pkg::BURST_W-1:0]    burst_out,
  input logic [sjfq_pkg::TIME_W-1:0]     start_time,
  input logic [sjfq_pkg::TIME_W-1:0]     finish_time,
  input logic [sjfq_pkg::SUM_W-1:0]      total_waiting,
  input logic                            is_last
);
  import sjfq_pkg::*;

  logic [TIME_W-1:0] end_calc;
  logic              res_empty, res_full, res_run;

  assign end_calc  = start_time + TIME_W'(burst_out);
  assign res_empty = strobe && (status == ST_EMPTY);
  assign res_full  = strobe && (status == ST_FULL);
  assign res_run   = strobe && (status == ST_DISPATCHED);

  `SJFQ_ASSERT_NOW(a_empty_result, res_empty, is_last && start_time == '0 && total_waiting == '0)
  `SJFQ_ASSERT_NOW(a_refused_result, res_full, !is_last && task_id == '0 && finish_time == '0)
  `SJFQ_ASSERT_NOW(a_finish_time, res_run, finish_time == end_calc)
  `SJFQ_ASSERT_NEXT(a_run_continues, res_run && !is_last, res_run && start_time == $past(finish_time))

endmodule

bind shortest_job_first_queue_unit sjfq_checker u_sjfq_checker (.*);
